// File: design/icp_quaternion_jacobian_row_macros.svh
// Assertion helpers for the Jacobian row block.
// Both expect clk and rst in scope.
`ifndef ICP_QUATERNION_JACOBIAN_ROW_MACROS_SVH
`define ICP_QUATERNION_JACOBIAN_ROW_MACROS_SVH

// same-cycle implication
`define ICPQJ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ICPQJ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/icpqj_pkg.sv
package icpqj_pkg;

  localparam int DATA_WIDTH      = 32;
  localparam int POINT_FRAC_BITS = 16;
  // fraction bits of the unit quaternion u = q / |q|
  localparam int UFRAC           = 30;

  // scaled quaternion, squared norm, root (root reaches 2^(UFRAC+1) when all
  // four parts sit at -2^UFRAC)
  localparam int QNW   = UFRAC + 1;
  localparam int N2W   = 2 * UFRAC + 3;
  localparam int NITER = (N2W + 1) / 2;
  localparam int SQW   = 2 * NITER;
  localparam int NW    = UFRAC + 2;
  localparam int LW    = $clog2(DATA_WIDTH + 1);
  localparam int SHW   = DATA_WIDTH + UFRAC;

  // divider
  localparam int QB    = UFRAC + 1;
  localparam int DVW   = QNW + UFRAC;
  localparam int REMW  = NW + 1;

  // datapath widths after each rounding
  localparam int UW    = UFRAC + 2;
  localparam int PW    = DATA_WIDTH + UW;
  localparam int JACC  = PW + 3;
  localparam int JW    = JACC - UFRAC;
  localparam int JLO   = JW / 2;
  localparam int JHI   = JW - JLO;
  localparam int RJW   = DATA_WIDTH + JW;
  localparam int VACC  = RJW + 2;
  localparam int VW    = VACC - POINT_FRAC_BITS;
  localparam int VLO   = VW / 2;
  localparam int VHI   = VW - VLO;
  localparam int USW   = UW + VW;
  localparam int SACC  = USW + 2;
  localparam int SW    = SACC - UFRAC;
  localparam int SLO   = SW / 2;
  localparam int SHI   = SW - SLO;
  localparam int UPW   = UW + SW;
  localparam int OW    = UPW + 2 - UFRAC;

  localparam int SQ_LAT  = NITER + 1;
  localparam int DIV_LAT = QB + 1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  // one term of a rotation-derivative entry: c * a[ai] * u[ui]
  typedef struct packed {
    logic signed [3:0] c;
    logic [1:0]        ai;
    logic [1:0]        ui;
  } jterm_t;

  // rows x,y,z by columns w,x,y,z
  localparam jterm_t JTAB [12][3] = '{
    '{'{ 4'sd2, 2'd2, 2'd2}, '{-4'sd2, 2'd1, 2'd3}, '{ 4'sd0, 2'd0, 2'd0}},
    '{'{ 4'sd2, 2'd1, 2'd2}, '{ 4'sd2, 2'd2, 2'd3}, '{ 4'sd0, 2'd0, 2'd0}},
    '{'{ 4'sd2, 2'd2, 2'd0}, '{-4'sd4, 2'd0, 2'd2}, '{ 4'sd2, 2'd1, 2'd1}},
    '{'{ 4'sd2, 2'd2, 2'd1}, '{-4'sd4, 2'd0, 2'd3}, '{-4'sd2, 2'd1, 2'd0}},
    '{'{ 4'sd2, 2'd0, 2'd3}, '{-4'sd2, 2'd2, 2'd1}, '{ 4'sd0, 2'd0, 2'd0}},
    '{'{ 4'sd2, 2'd0, 2'd2}, '{-4'sd2, 2'd2, 2'd0}, '{-4'sd4, 2'd1, 2'd1}},
    '{'{ 4'sd2, 2'd0, 2'd1}, '{ 4'sd2, 2'd2, 2'd3}, '{ 4'sd0, 2'd0, 2'd0}},
    '{'{ 4'sd2, 2'd0, 2'd0}, '{-4'sd4, 2'd1, 2'd3}, '{ 4'sd2, 2'd2, 2'd2}},
    '{'{ 4'sd2, 2'd1, 2'd1}, '{-4'sd2, 2'd0, 2'd2}, '{ 4'sd0, 2'd0, 2'd0}},
    '{'{ 4'sd2, 2'd1, 2'd0}, '{ 4'sd2, 2'd0, 2'd3}, '{-4'sd4, 2'd2, 2'd1}},
    '{'{ 4'sd2, 2'd1, 2'd3}, '{-4'sd2, 2'd0, 2'd0}, '{-4'sd4, 2'd2, 2'd2}},
    '{'{ 4'sd2, 2'd0, 2'd1}, '{ 4'sd2, 2'd1, 2'd2}, '{ 4'sd0, 2'd0, 2'd0}}
  };

  // c * p for c in {0, +-2, +-4}
  function automatic logic signed [JACC-1:0] jterm_scale(logic signed [3:0] c,
                                                        logic signed [PW-1:0] p);
    logic signed [JACC-1:0] e;
    e = JACC'(p);
    case (c)
      4'sd2:   return e <<< 1;
      -4'sd2:  return -(e <<< 1);
      4'sd4:   return e <<< 2;
      -4'sd4:  return -(e <<< 2);
      default: return '0;
    endcase
  endfunction

endpackage

// File: design/icpqj_sqrt_pipe.sv
// Integer square root, one result bit (one radicand bit pair) per stage.
module icpqj_sqrt_pipe
  import icpqj_pkg::*;
(
  input  logic           clk,
  input  logic [N2W-1:0] x,
  output logic [NW-1:0]  root
);

  logic [SQW-1:0] rem_q [NITER+1];
  logic [SQW-1:0] res_q [NITER+1];

  always_ff @(posedge clk) begin
    rem_q[0] <= SQW'(x);
    res_q[0] <= '0;
  end

  for (genvar k = 0; k < NITER; k++) begin : g_step
    localparam logic [SQW-1:0] BITV = SQW'(1) << (2 * (NITER - 1 - k));
    logic [SQW-1:0] trial;
    assign trial = res_q[k] + BITV;
    always_ff @(posedge clk) begin
      if (rem_q[k] >= trial) begin
        rem_q[k+1] <= rem_q[k] - trial;
        res_q[k+1] <= (res_q[k] >> 1) + BITV;
      end else begin
        rem_q[k+1] <= rem_q[k];
        res_q[k+1] <= res_q[k] >> 1;
      end
    end
  end

  assign root = res_q[NITER][NW-1:0];

endmodule

// File: design/icpqj_div_pipe.sv
// Rounded quotient (mag * 2^UFRAC + n/2) / n, restoring, one bit per stage.
module icpqj_div_pipe
  import icpqj_pkg::*;
(
  input  logic           clk,
  input  logic [QNW-1:0] mag,
  input  logic [NW-1:0]  n,
  output logic [QB-1:0]  quo
);

  logic [DVW-1:0]  dvd;
  logic [REMW-1:0] rem_q [QB+1];
  logic [QB-1:0]   low_q [QB+1];
  logic [QB-1:0]   quo_q [QB+1];
  logic [NW-1:0]   n_q   [QB+1];

  assign dvd = (DVW'(mag) << UFRAC) + DVW'(n >> 1);

  always_ff @(posedge clk) begin
    rem_q[0] <= REMW'(dvd >> QB);
    low_q[0] <= dvd[QB-1:0];
    quo_q[0] <= '0;
    n_q[0]   <= n;
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [REMW:0] t;
    logic          ge;
    assign t  = {rem_q[k], low_q[k][QB-1]};
    assign ge = t >= (REMW + 1)'(n_q[k]);
    always_ff @(posedge clk) begin
      rem_q[k+1] <= ge ? REMW'(t - (REMW + 1)'(n_q[k])) : REMW'(t);
      low_q[k+1] <= low_q[k] << 1;
      quo_q[k+1] <= {quo_q[k][QB-2:0], ge};
      n_q[k+1]   <= n_q[k];
    end
  end

  assign quo = quo_q[QB];

endmodule

// File: design/icp_quaternion_jacobian_row.sv
// One ICP Jacobian row per beat: r^T * dR(q)a/dq * (|q|^2 I - q q^T)/|q|^3,
// evaluated as Jrot(u) * (I - u u^T) with u = q/|q|, so the scale of q drops
// out. A beat is taken on every cycle that start is high; busy is always low.
// Each result appears on the jac_* ports with done high for one cycle, in
// order; there is no back-pressure, so the receiver must take it then. The
// path runs through the 32-step square root of |q|^2 (one bit pair per
// stage) and the 31-step restoring divider that forms u (four lanes, one
// quotient bit per stage); the rest is 19 stages of normalize, multiply and
// round, with every product at most 32x32 and split into two partial
// products where an operand is wider. saturated flags an entry clipped to
// 32 bits; an all-zero quaternion gives zeros and degenerate.
`include "icp_quaternion_jacobian_row_macros.svh"

module icp_quaternion_jacobian_row
  import icpqj_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  data_t point_x,
  input  data_t point_y,
  input  data_t point_z,
  input  data_t quat_w,
  input  data_t quat_x,
  input  data_t quat_y,
  input  data_t quat_z,
  input  data_t resid_x,
  input  data_t resid_y,
  input  data_t resid_z,
  output logic  done,
  output data_t jac_w,
  output data_t jac_x,
  output data_t jac_y,
  output data_t jac_z,
  output logic  saturated,
  output logic  degenerate
);

  localparam int LAT = SQ_LAT + DIV_LAT + 19;
  localparam data_t OUT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t OUT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [OW-1:0] OMAX = OW'(OUT_MAX);
  localparam logic signed [OW-1:0] OMIN = OW'(OUT_MIN);

  // payload riding alongside the root and divider pipes
  typedef struct packed {
    logic                  deg;
    data_t [2:0]           a;
    data_t [2:0]           r;
    logic [3:0]            qneg;
    logic [3:0][QNW-1:0]   qmag;
  } pay_t;

  assign busy = 1'b0;

  // ---------------- valid chain ----------------
  logic f0v, f1v, f2v, f3v, f4v, f5v;
  logic [SQ_LAT-1:0]  sq_vl;
  logic [DIV_LAT-1:0] dv_vl;
  logic uv, pv, jv, v1v, v2v, v3v, d1v, d2v, d3v, c1v, c2v, c3v;

  always_ff @(posedge clk) begin
    if (rst) begin
      f0v <= 1'b0; f1v <= 1'b0; f2v <= 1'b0; f3v <= 1'b0; f4v <= 1'b0; f5v <= 1'b0;
      sq_vl <= '0;
      dv_vl <= '0;
      uv <= 1'b0; pv <= 1'b0; jv <= 1'b0;
      v1v <= 1'b0; v2v <= 1'b0; v3v <= 1'b0;
      d1v <= 1'b0; d2v <= 1'b0; d3v <= 1'b0;
      c1v <= 1'b0; c2v <= 1'b0; c3v <= 1'b0;
      done <= 1'b0;
    end else begin
      f0v <= start & ~busy;
      f1v <= f0v; f2v <= f1v; f3v <= f2v; f4v <= f3v; f5v <= f4v;
      sq_vl <= {sq_vl[SQ_LAT-2:0], f5v};
      dv_vl <= {dv_vl[DIV_LAT-2:0], sq_vl[SQ_LAT-1]};
      uv <= dv_vl[DIV_LAT-1];
      pv <= uv; jv <= pv;
      v1v <= jv; v2v <= v1v; v3v <= v2v;
      d1v <= v3v; d2v <= d1v; d3v <= d2v;
      c1v <= d3v; c2v <= c1v; c3v <= c2v;
      done <= c3v;
    end
  end

  // ---------------- front end: capture, normalize, |q|^2 ----------------
  data_t f0_a [3], f0_r [3], f0_q [4];
  data_t f1_a [3], f1_r [3], f1_q [4];
  data_t f2_a [3], f2_r [3], f2_q [4];
  logic [DATA_WIDTH-1:0] f1_m;
  logic [LW-1:0]         f2_l;
  logic                  f2_deg, f3_deg, f4_deg;
  data_t f3_a [3], f3_r [3], f4_a [3], f4_r [3];
  logic signed [QNW-1:0] f3_qs [4], f4_qs [4];
  logic [2*QNW-1:0]      f4_sq [4];
  logic [N2W-1:0]        f5_n2;
  pay_t                  f5_pay;

  logic [DATA_WIDTH-1:0] qmag_c [4];
  logic [DATA_WIDTH-1:0] m01_c, m23_c;
  logic [LW-1:0]         l_c;
  logic signed [SHW-1:0] sh_c [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qmag_c[i] = f0_q[i][DATA_WIDTH-1] ? DATA_WIDTH'(-f0_q[i]) : f0_q[i];
    end
    m01_c = (qmag_c[0] > qmag_c[1]) ? qmag_c[0] : qmag_c[1];
    m23_c = (qmag_c[2] > qmag_c[3]) ? qmag_c[2] : qmag_c[3];
  end

  // bit length of the largest magnitude
  always_comb begin
    l_c = '0;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      if (f1_m[i]) l_c = LW'(i + 1);
    end
  end

  // bring the largest part to exactly UFRAC bits (floor on right shift)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (f2_l < LW'(UFRAC)) begin
        sh_c[i] = SHW'(f2_q[i]) <<< (LW'(UFRAC) - f2_l);
      end else begin
        sh_c[i] = SHW'(f2_q[i]) >>> (f2_l - LW'(UFRAC));
      end
    end
  end

  always_ff @(posedge clk) begin
    f0_a[0] <= point_x; f0_a[1] <= point_y; f0_a[2] <= point_z;
    f0_r[0] <= resid_x; f0_r[1] <= resid_y; f0_r[2] <= resid_z;
    f0_q[0] <= quat_w;  f0_q[1] <= quat_x;  f0_q[2] <= quat_y;  f0_q[3] <= quat_z;

    f1_a <= f0_a; f1_r <= f0_r; f1_q <= f0_q;
    f1_m <= (m01_c > m23_c) ? m01_c : m23_c;

    f2_a <= f1_a; f2_r <= f1_r; f2_q <= f1_q;
    f2_l <= l_c;
    f2_deg <= (f1_m == '0);

    f3_a <= f2_a; f3_r <= f2_r; f3_deg <= f2_deg;
    for (int i = 0; i < 4; i++) f3_qs[i] <= sh_c[i][QNW-1:0];

    f4_a <= f3_a; f4_r <= f3_r; f4_deg <= f3_deg; f4_qs <= f3_qs;
    for (int i = 0; i < 4; i++) f4_sq[i] <= f3_qs[i] * f3_qs[i];

    f5_n2 <= N2W'(f4_sq[0]) + N2W'(f4_sq[1]) + N2W'(f4_sq[2]) + N2W'(f4_sq[3]);
    f5_pay.deg <= f4_deg;
    for (int i = 0; i < 3; i++) begin
      f5_pay.a[i] <= f4_a[i];
      f5_pay.r[i] <= f4_r[i];
    end
    for (int i = 0; i < 4; i++) begin
      f5_pay.qneg[i] <= f4_qs[i][QNW-1];
      f5_pay.qmag[i] <= f4_qs[i][QNW-1] ? QNW'(-f4_qs[i]) : QNW'(f4_qs[i]);
    end
  end

  // ---------------- norm and unit quaternion ----------------
  logic [NW-1:0] root;
  pay_t sq_dl [SQ_LAT];
  pay_t dv_dl [DIV_LAT];
  logic [QB-1:0] quo [4];

  icpqj_sqrt_pipe u_sqrt (
    .clk  (clk),
    .x    (f5_n2),
    .root (root)
  );

  for (genvar i = 0; i < 4; i++) begin : g_div
    icpqj_div_pipe u_div (
      .clk (clk),
      .mag (sq_dl[SQ_LAT-1].qmag[i]),
      .n   (root),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    sq_dl[0] <= f5_pay;
    for (int k = 1; k < SQ_LAT; k++) sq_dl[k] <= sq_dl[k-1];
    dv_dl[0] <= sq_dl[SQ_LAT-1];
    for (int k = 1; k < DIV_LAT; k++) dv_dl[k] <= dv_dl[k-1];
  end

  // ---------------- rotation derivative Jrot(u) ----------------
  logic signed [UW-1:0] u_u [4], p_u [4], j_u [4], v1_u [4], v2_u [4], v3_u [4];
  logic signed [UW-1:0] d1_u [4], d2_u [4], d3_u [4];
  data_t u_a [3], u_r [3], p_r [3], j_r [3];
  logic u_deg, p_deg, j_deg, v1_deg, v2_deg, v3_deg, d1_deg, d2_deg, d3_deg;
  logic c1_deg, c2_deg, c3_deg;
  logic signed [PW-1:0]   p_prod [3][4];
  logic signed [JACC-1:0] jacc_c [12];
  logic signed [JW-1:0]   j_jm [12];

  always_comb begin
    for (int e = 0; e < 12; e++) begin
      jacc_c[e] = jterm_scale(JTAB[e][0].c, p_prod[JTAB[e][0].ai][JTAB[e][0].ui])
                + jterm_scale(JTAB[e][1].c, p_prod[JTAB[e][1].ai][JTAB[e][1].ui])
                + jterm_scale(JTAB[e][2].c, p_prod[JTAB[e][2].ai][JTAB[e][2].ui])
                + (JACC'(1) <<< (UFRAC - 1));
    end
  end

  always_ff @(posedge clk) begin
    u_deg <= dv_dl[DIV_LAT-1].deg;
    for (int i = 0; i < 3; i++) begin
      u_a[i] <= $signed(dv_dl[DIV_LAT-1].a[i]);
      u_r[i] <= $signed(dv_dl[DIV_LAT-1].r[i]);
    end
    for (int k = 0; k < 4; k++) begin
      u_u[k] <= dv_dl[DIV_LAT-1].qneg[k] ? -$signed(UW'(quo[k])) : $signed(UW'(quo[k]));
    end

    p_deg <= u_deg; p_r <= u_r; p_u <= u_u;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 4; k++) p_prod[j][k] <= u_a[j] * u_u[k];
    end

    j_deg <= p_deg; j_r <= p_r; j_u <= p_u;
    for (int e = 0; e < 12; e++) j_jm[e] <= JW'(jacc_c[e] >>> UFRAC);
  end

  // ---------------- v = r^T * Jrot ----------------
  logic signed [DATA_WIDTH+JLO:0]   v1_lo [12];
  logic signed [DATA_WIDTH+JHI-1:0] v1_hi [12];
  logic signed [RJW-1:0]            v2_prod [12];
  logic signed [VACC-1:0]           vacc_c [4];
  logic signed [VW-1:0]             v3_v [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      vacc_c[k] = VACC'(v2_prod[k]) + VACC'(v2_prod[4 + k]) + VACC'(v2_prod[8 + k])
                + (VACC'(1) <<< (POINT_FRAC_BITS - 1));
    end
  end

  always_ff @(posedge clk) begin
    v1_deg <= j_deg; v1_u <= j_u;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 4; k++) begin
        v1_lo[i*4+k] <= j_r[i] * $signed({1'b0, j_jm[i*4+k][JLO-1:0]});
        v1_hi[i*4+k] <= j_r[i] * $signed(j_jm[i*4+k][JW-1:JLO]);
      end
    end

    v2_deg <= v1_deg; v2_u <= v1_u;
    for (int e = 0; e < 12; e++) begin
      v2_prod[e] <= (RJW'(v1_hi[e]) <<< JLO) + RJW'(v1_lo[e]);
    end

    v3_deg <= v2_deg; v3_u <= v2_u;
    for (int k = 0; k < 4; k++) v3_v[k] <= VW'(vacc_c[k] >>> POINT_FRAC_BITS);
  end

  // ---------------- s = u . v ----------------
  logic signed [UW+VLO:0]   d1_lo [4];
  logic signed [UW+VHI-1:0] d1_hi [4];
  logic signed [USW-1:0]    d2_prod [4];
  logic signed [VW-1:0]     d1_v [4], d2_v [4], d3_v [4], c1_v [4], c2_v [4];
  logic signed [SACC-1:0]   sacc_c;
  logic signed [SW-1:0]     d3_s;

  assign sacc_c = SACC'(d2_prod[0]) + SACC'(d2_prod[1]) + SACC'(d2_prod[2])
                + SACC'(d2_prod[3]) + (SACC'(1) <<< (UFRAC - 1));

  always_ff @(posedge clk) begin
    d1_deg <= v3_deg; d1_u <= v3_u; d1_v <= v3_v;
    for (int k = 0; k < 4; k++) begin
      d1_lo[k] <= v3_u[k] * $signed({1'b0, v3_v[k][VLO-1:0]});
      d1_hi[k] <= v3_u[k] * $signed(v3_v[k][VW-1:VLO]);
    end

    d2_deg <= d1_deg; d2_u <= d1_u; d2_v <= d1_v;
    for (int k = 0; k < 4; k++) d2_prod[k] <= (USW'(d1_hi[k]) <<< VLO) + USW'(d1_lo[k]);

    d3_deg <= d2_deg; d3_u <= d2_u; d3_v <= d2_v;
    d3_s <= SW'(sacc_c >>> UFRAC);
  end

  // ---------------- jac = v - u * s, rounded, clamped ----------------
  logic signed [UW+SLO:0]   c1_lo [4];
  logic signed [UW+SHI-1:0] c1_hi [4];
  logic signed [UPW-1:0]    c2_prod [4];
  logic signed [OW-1:0]     c3_o [4];
  logic signed [UPW:0]      corr_c [4];
  logic signed [OW-1:0]     clip_c [4];
  logic [3:0]               clip_hit_c;

  // v*2^UFRAC is exact, so only the u*s part carries the rounding
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      corr_c[k] = ((UPW + 1)'(1) <<< (UFRAC - 1)) - (UPW + 1)'(c2_prod[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      clip_hit_c[k] = 1'b0;
      clip_c[k] = c3_o[k];
      if (c3_o[k] > OMAX) begin
        clip_c[k] = OMAX;
        clip_hit_c[k] = 1'b1;
      end else if (c3_o[k] < OMIN) begin
        clip_c[k] = OMIN;
        clip_hit_c[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    c1_deg <= d3_deg; c1_v <= d3_v;
    for (int k = 0; k < 4; k++) begin
      c1_lo[k] <= d3_u[k] * $signed({1'b0, d3_s[SLO-1:0]});
      c1_hi[k] <= d3_u[k] * $signed(d3_s[SW-1:SLO]);
    end

    c2_deg <= c1_deg; c2_v <= c1_v;
    for (int k = 0; k < 4; k++) c2_prod[k] <= (UPW'(c1_hi[k]) <<< SLO) + UPW'(c1_lo[k]);

    c3_deg <= c2_deg;
    for (int k = 0; k < 4; k++) c3_o[k] <= OW'(c2_v[k]) + OW'(corr_c[k] >>> UFRAC);

    if (c3_deg) begin
      jac_w <= '0; jac_x <= '0; jac_y <= '0; jac_z <= '0;
      saturated  <= 1'b0;
      degenerate <= 1'b1;
    end else begin
      jac_w <= DATA_WIDTH'(clip_c[0]);
      jac_x <= DATA_WIDTH'(clip_c[1]);
      jac_y <= DATA_WIDTH'(clip_c[2]);
      jac_z <= DATA_WIDTH'(clip_c[3]);
      saturated  <= |clip_hit_c;
      degenerate <= 1'b0;
    end
  end

  // ---------------- checks ----------------
  logic row_zero, rail_hit;

  assign row_zero = (jac_w == '0) && (jac_x == '0) && (jac_y == '0) && (jac_z == '0);
  assign rail_hit = (jac_w == OUT_MAX) || (jac_w == OUT_MIN)
                 || (jac_x == OUT_MAX) || (jac_x == OUT_MIN)
                 || (jac_y == OUT_MAX) || (jac_y == OUT_MIN)
                 || (jac_z == OUT_MAX) || (jac_z == OUT_MIN);

  `ICPQJ_ASSERT_IMP(a_deg_zero, done && degenerate, row_zero && !saturated, "deg row nonzero")
  `ICPQJ_ASSERT_IMP(a_sat_bound, done && saturated, !degenerate && rail_hit, "no clipped entry")
  `ICPQJ_ASSERT_IMP(a_latency, done, $past(start, LAT), "result beat without a start beat")

endmodule
